FILE: rtl/jbf_pkg.sv
`timescale 1ns / 1ps
package jbf_pkg;

    // Frame geometry.
    localparam int MAX_WIDTH   = 1024;
    localparam int RADIUS      = 2;
    localparam int WIN_SIDE    = 2 * RADIUS + 1;
    localparam int TAPS        = WIN_SIDE * WIN_SIDE;
    localparam int RING_DEPTH  = WIN_SIDE * MAX_WIDTH;
    localparam int RING_AW     = $clog2(RING_DEPTH);
    localparam int FW_W        = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W       = 13;
    localparam int CNT_W       = FW_W + ROW_W;

    // Sample and accumulator widths.
    localparam int SAMPLE_W    = 16;
    localparam int WSUM_W      = SAMPLE_W + $clog2(TAPS);
    localparam int SUM_W       = 2 * SAMPLE_W + $clog2(TAPS);

    // Default depth of the command queue between front and back.
    localparam int DEF_QUEUE_DEPTH = 4;

    // Exponential weight table, Q0.16, covering arguments 0 to 16.0.
    localparam int          EXP_ENTRIES = 256;
    localparam int          EXP_IDX_W   = $clog2(EXP_ENTRIES);
    localparam logic [63:0] EXP_LIMIT   = 64'h0000_0000_0010_0000;
    localparam logic [63:0] INV_E_Q32   = 64'd1580030169;

    typedef logic [15:0] exp_table_t [EXP_ENTRIES];

    // Each entry is exp(-16*i/N): a Taylor series on the fraction, then one
    // rounded multiply by 1/e for every whole unit, then rounding to Q16.
    function automatic exp_table_t build_exp_table();
        exp_table_t  tbl;
        logic [63:0] x;
        logic [63:0] t;
        logic [63:0] term;
        logic [63:0] v;
        logic [63:0] r;
        longint      acc;
        int          a;
        for (int i = 0; i < EXP_ENTRIES; i++) begin
            x    = (64'(i) << 36) / EXP_ENTRIES;
            a    = int'(x >> 32);
            t    = x & 64'h0000_0000_FFFF_FFFF;
            term = 64'h0000_0001_0000_0000;
            acc  = longint'(term);
            for (int k = 1; k <= 24; k++) begin
                term = ((term * t) >> 32) / 64'(k);
                if ((k & 1) != 0) begin
                    acc = acc - longint'(term);
                end
                else begin
                    acc = acc + longint'(term);
                end
            end
            v = (acc > 0) ? 64'(acc) : 64'd0;
            for (int j = 0; j < a; j++) begin
                v = (v * INV_E_Q32 + 64'h0000_0000_8000_0000) >> 32;
            end
            r = (v + 64'd32768) >> 16;
            tbl[i] = (r > 64'd65535) ? 16'hFFFF : r[15:0];
        end
        return tbl;
    endfunction

    localparam exp_table_t EXP_TABLE = build_exp_table();

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH      = 2'd0,
        CFG_IMAGE_HEIGHT     = 2'd1,
        CFG_INV_TWO_SIGMA_SQ = 2'd2,
        CFG_BOX_MODE         = 2'd3
    } cfg_index_t;

    typedef struct packed {
        opcode_t              opcode;
        logic [SAMPLE_W-1:0]  pixel_value;
        logic [SAMPLE_W-1:0]  guide_value;
    } in_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0]  filtered_value;
        logic                 frame_end;
    } out_item_t;

    // One command from the front: an optional line store write followed by
    // an optional output computation.
    typedef struct packed {
        logic                 do_write;
        logic [RING_AW-1:0]   wr_addr;
        logic [SAMPLE_W-1:0]  value;
        logic [SAMPLE_W-1:0]  guide;
        logic                 do_emit;
        logic [RING_AW-1:0]   ctr_addr;
        logic [ROW_W-1:0]     out_row;
        logic [FW_W-1:0]      out_col;
        logic [FW_W-1:0]      frame_w;
        logic [ROW_W-1:0]     frame_h;
        logic                 frame_end;
    } cmd_t;

endpackage

FILE: rtl/joint_bilateral_filter_5x5.sv
`timescale 1ns / 1ps
// Channel   Signals                                Direction  Accepted when
// pix       pix_valid, pix_stall, pix_item         in         pix_valid high, pix_stall low
// res       res_valid, res_stall, res_item         out        res_valid high, res_stall low
// cfg       cfg_valid, cfg_ready, cfg_index/data   in         cfg_valid high, cfg_ready high
//
// An item that causes no result at most writes its pixel to the line store.
// An item that causes a result, after that write when it also writes a pixel,
// goes through a center read, 25 tap reads at one per cycle through the single
// read port of the line store, a drain of the six-stage weight pipeline and a
// divider that works out the 16 quotient bits one after another.
// Reset is asynchronous and active low; the line store needs no clearing pass.
// The pixel channel stalls only when the command queue is full; a finished
// result waits in the output register while the next command proceeds.
module joint_bilateral_filter_5x5 #(
    parameter int CMD_QUEUE_DEPTH = jbf_pkg::DEF_QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pix_valid,
    output logic               pix_stall,
    input  jbf_pkg::in_item_t  pix_item,
    output logic               res_valid,
    input  logic               res_stall,
    output jbf_pkg::out_item_t res_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import jbf_pkg::*;

    // Configuration registers. The frame size is sampled by the front end at
    // the first pixel of a frame; the weight settings are used by the back end
    // directly.
    logic [10:0] image_width_reg;
    logic [12:0] image_height_reg;
    logic [31:0] inv_two_sigma_sq_reg;
    logic        box_mode_reg;

    // Command queue between the classifying front end and the filter back end.
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    cmd_t q_in_cmd;
    cmd_t q_out_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            image_width_reg      <= 11'd320;
            image_height_reg     <= 13'd240;
            inv_two_sigma_sq_reg <= 32'd32768;
            box_mode_reg         <= 1'b0;
        end
        else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_IMAGE_WIDTH:      image_width_reg      <= cfg_data[10:0];
                CFG_IMAGE_HEIGHT:     image_height_reg     <= cfg_data[12:0];
                CFG_INV_TWO_SIGMA_SQ: inv_two_sigma_sq_reg <= cfg_data;
                CFG_BOX_MODE:         box_mode_reg         <= cfg_data[0];
                default:              box_mode_reg         <= box_mode_reg;
            endcase
        end
    end

    // The front end tracks input and output raster positions and turns each
    // item into a store write, an output request, both or nothing.
    jbf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pix_valid    (pix_valid),
        .pix_stall    (pix_stall),
        .pix_item     (pix_item),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (q_in_cmd)
    );

    jbf_queue #(
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_in_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (q_out_cmd),
        .empty    (q_empty)
    );

    // The back end owns the line store, so writes and window reads stay in
    // command order.
    jbf_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .q_cmd            (q_out_cmd),
        .q_pop            (q_pop),
        .inv_two_sigma_sq (inv_two_sigma_sq_reg),
        .box_mode         (box_mode_reg),
        .res_valid        (res_valid),
        .res_stall        (res_stall),
        .res_item         (res_item)
    );

endmodule

FILE: rtl/jbf_queue.sv
`timescale 1ns / 1ps
module jbf_queue #(
    parameter int DEPTH = jbf_pkg::DEF_QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  jbf_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output jbf_pkg::cmd_t pop_cmd,
    output logic          empty
);
    import jbf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          slot_mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = slot_mem[rd_ptr_reg];

    always_ff @(posedge clk) begin
        if (push) begin
            slot_mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

FILE: rtl/jbf_front.sv
`timescale 1ns / 1ps
module jbf_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pix_valid,
    output logic              pix_stall,
    input  jbf_pkg::in_item_t pix_item,
    input  logic [10:0]       image_width,
    input  logic [12:0]       image_height,
    input  logic              q_full,
    output logic              q_push,
    output jbf_pkg::cmd_t     q_cmd
);
    import jbf_pkg::*;

    logic [CNT_W-1:0]   n_reg, n_next;
    logic [RING_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]   o_reg, o_next;
    logic [RING_AW-1:0] o_ptr_reg, o_ptr_next;
    logic [ROW_W-1:0]   out_row_reg, out_row_next;
    logic [FW_W-1:0]    out_col_reg, out_col_next;
    logic [FW_W-1:0]    fw_reg, fw_next;
    logic [ROW_W-1:0]   fh_reg, fh_next;
    logic               done_reg, done_next;

    logic               accept;
    logic               start;
    logic               is_pixel;
    logic               do_emit;
    logic               last_out;
    logic [FW_W-1:0]    clamp_w;
    logic [ROW_W-1:0]   clamp_h;
    logic [FW_W-1:0]    fw;
    logic [ROW_W-1:0]   fh;
    logic [CNT_W-1:0]   total;
    logic [CNT_W-1:0]   lag;

    assign pix_stall = q_full;
    assign accept    = pix_valid && !q_full;
    assign start     = (n_reg == '0);

    always_comb begin
        if (image_width == '0) begin
            clamp_w = FW_W'(1);
        end
        else if (32'(image_width) > MAX_WIDTH) begin
            clamp_w = FW_W'(MAX_WIDTH);
        end
        else begin
            clamp_w = FW_W'(image_width);
        end
        clamp_h = (image_height == '0) ? ROW_W'(1) : image_height;
    end

    // The frame size is taken from the registers at the first pixel.
    assign fw       = start ? clamp_w : fw_reg;
    assign fh       = start ? clamp_h : fh_reg;
    assign total    = CNT_W'(fw) * CNT_W'(fh);
    assign lag      = CNT_W'(fw) * CNT_W'(RADIUS) + CNT_W'(RADIUS);
    assign is_pixel = !done_reg && (pix_item.opcode == OP_PIXEL);
    assign do_emit  = done_reg || (is_pixel && (n_reg >= lag));
    assign last_out = ((o_reg + CNT_W'(1)) == total);
    assign q_push   = accept && (is_pixel || do_emit);

    always_comb begin
        q_cmd.do_write  = is_pixel;
        q_cmd.wr_addr   = wr_ptr_reg;
        q_cmd.value     = pix_item.pixel_value;
        q_cmd.guide     = pix_item.guide_value;
        q_cmd.do_emit   = do_emit;
        q_cmd.ctr_addr  = o_ptr_reg;
        q_cmd.out_row   = out_row_reg;
        q_cmd.out_col   = out_col_reg;
        q_cmd.frame_w   = fw;
        q_cmd.frame_h   = fh;
        q_cmd.frame_end = last_out;
    end

    always_comb begin
        n_next       = n_reg;
        wr_ptr_next  = wr_ptr_reg;
        o_next       = o_reg;
        o_ptr_next   = o_ptr_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        fw_next      = fw_reg;
        fh_next      = fh_reg;
        done_next    = done_reg;
        if (accept) begin
            if (is_pixel) begin
                n_next = n_reg + CNT_W'(1);
                wr_ptr_next = (wr_ptr_reg == RING_AW'(RING_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + RING_AW'(1);
                if (start) begin
                    fw_next = clamp_w;
                    fh_next = clamp_h;
                end
                if ((n_reg + CNT_W'(1)) == total) begin
                    done_next = 1'b1;
                end
            end
            if (do_emit) begin
                if (last_out) begin
                    n_next       = '0;
                    wr_ptr_next  = '0;
                    o_next       = '0;
                    o_ptr_next   = '0;
                    out_row_next = '0;
                    out_col_next = '0;
                    done_next    = 1'b0;
                end
                else begin
                    o_next = o_reg + CNT_W'(1);
                    o_ptr_next = (o_ptr_reg == RING_AW'(RING_DEPTH - 1)) ?
                                 '0 : o_ptr_reg + RING_AW'(1);
                    if ((out_col_reg + FW_W'(1)) == fw) begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + ROW_W'(1);
                    end
                    else begin
                        out_col_next = out_col_reg + FW_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            n_reg       <= '0;
            wr_ptr_reg  <= '0;
            o_reg       <= '0;
            o_ptr_reg   <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            fw_reg      <= FW_W'(1);
            fh_reg      <= ROW_W'(1);
            done_reg    <= 1'b0;
        end
        else begin
            n_reg       <= n_next;
            wr_ptr_reg  <= wr_ptr_next;
            o_reg       <= o_next;
            o_ptr_reg   <= o_ptr_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
            fw_reg      <= fw_next;
            fh_reg      <= fh_next;
            done_reg    <= done_next;
        end
    end

endmodule

FILE: rtl/jbf_back.sv
`timescale 1ns / 1ps
module jbf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  jbf_pkg::cmd_t      q_cmd,
    output logic               q_pop,
    input  logic [31:0]        inv_two_sigma_sq,
    input  logic               box_mode,
    output logic               res_valid,
    input  logic               res_stall,
    output jbf_pkg::out_item_t res_item
);
    import jbf_pkg::*;

    localparam int D2_W    = 5;
    localparam int AOFF_W  = FW_W + 4;
    localparam int AD_W    = RING_AW + 2;
    localparam int DIV_CW  = $clog2(SAMPLE_W);
    localparam logic signed [2:0] TAP_LO = 3'(-RADIUS);
    localparam logic signed [2:0] TAP_HI = 3'(RADIUS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_CTR_RD,
        S_CTR_WAIT,
        S_TAPS,
        S_DRAIN,
        S_DIVIDE,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic [SAMPLE_W-1:0] guide;
    } ring_word_t;

    function automatic logic [15:0] wlook(input logic [63:0] x, input logic scale_zero);
        logic [15:0] w;
        if (scale_zero) begin
            w = EXP_TABLE[0];
        end
        else if (x >= EXP_LIMIT) begin
            w = '0;
        end
        else begin
            w = EXP_TABLE[x[19 -: EXP_IDX_W]];
        end
        return w;
    endfunction

    state_t                state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [SAMPLE_W-1:0]   gc_reg, gc_next;
    logic signed [2:0]     tk_reg, tk_next;
    logic signed [2:0]     tm_reg, tm_next;
    logic [WSUM_W-1:0]     wsum_reg, wsum_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [WSUM_W:0]       rem_reg, rem_next;
    logic [SAMPLE_W-1:0]   quo_reg, quo_next;
    logic [DIV_CW-1:0]     bit_cnt_reg, bit_cnt_next;
    logic                  res_valid_reg, res_valid_next;
    out_item_t             res_item_reg, res_item_next;

    ring_word_t            ring_mem [RING_DEPTH];
    ring_word_t            rd_q;
    logic [RING_AW-1:0]    rd_addr;

    // Tap pipeline.
    logic                  p1_vld_reg, p2_vld_reg, p3_vld_reg;
    logic                  p4_vld_reg, p5_vld_reg, p6_vld_reg;
    logic                  p1_ok_reg, p2_ok_reg, p3_ok_reg, p4_ok_reg;
    logic [D2_W-1:0]       p1_d2_reg, p2_d2_reg;
    logic [31:0]           p2_dsq_reg;
    logic [SAMPLE_W-1:0]   p2_v_reg, p3_v_reg, p4_v_reg, p5_v_reg;
    logic [D2_W+31:0]      p3_xs_reg;
    logic [63:0]           p3_xg_reg;
    logic [15:0]           p4_ws_reg, p4_wg_reg;
    logic [15:0]           p5_wt_reg, p6_wt_reg;
    logic [31:0]           p6_prod_reg;

    logic                  tap_issue;
    logic signed [ROW_W+1:0] rr;
    logic signed [FW_W+1:0]  cc;
    logic                  tap_ok;
    logic signed [5:0]     tk6, tm6, d2_s;
    logic [D2_W-1:0]       tap_d2;
    logic signed [AOFF_W-1:0] kw, off;
    logic signed [AD_W-1:0]   addr_s;
    logic [RING_AW-1:0]    tap_addr;
    logic [SAMPLE_W-1:0]   diff;
    logic [31:0]           ww;
    logic [WSUM_W+1:0]     trial;
    logic                  ge;
    logic                  scale_zero;

    assign scale_zero = (inv_two_sigma_sq == '0);
    assign tap_issue  = (state_reg == S_TAPS);
    assign res_valid  = res_valid_reg;
    assign res_item   = res_item_reg;

    // Neighbor position, bounds and ring address of the current tap.
    always_comb begin
        rr = $signed({2'b00, cmd_reg.out_row}) + (ROW_W + 2)'(tk_reg);
        cc = $signed({2'b00, cmd_reg.out_col}) + (FW_W + 2)'(tm_reg);
        tap_ok = (rr >= 0) && (rr < $signed({2'b00, cmd_reg.frame_h}))
              && (cc >= 0) && (cc < $signed({2'b00, cmd_reg.frame_w}));
        tk6    = 6'(tk_reg);
        tm6    = 6'(tm_reg);
        d2_s   = tk6 * tk6 + tm6 * tm6;
        tap_d2 = D2_W'(d2_s);
        kw     = AOFF_W'(tk_reg) * $signed({4'b0000, cmd_reg.frame_w});
        off    = kw + AOFF_W'(tm_reg);
        addr_s = $signed({2'b00, cmd_reg.ctr_addr}) + AD_W'(off);
        if (addr_s < 0) begin
            addr_s = addr_s + AD_W'(RING_DEPTH);
        end
        else if (addr_s >= AD_W'(RING_DEPTH)) begin
            addr_s = addr_s - AD_W'(RING_DEPTH);
        end
        tap_addr = addr_s[RING_AW-1:0];
        rd_addr  = (state_reg == S_CTR_RD) ? cmd_reg.ctr_addr : tap_addr;
    end

    always_ff @(posedge clk) begin
        if (state_reg == S_WRITE) begin
            ring_mem[cmd_reg.wr_addr] <= '{value: cmd_reg.value, guide: cmd_reg.guide};
        end
        rd_q <= ring_mem[rd_addr];
    end

    always_comb begin
        diff = (rd_q.guide > gc_reg) ? (rd_q.guide - gc_reg) : (gc_reg - rd_q.guide);
        ww   = 32'(p4_ws_reg) * 32'(p4_wg_reg);
    end

    always_ff @(posedge clk) begin
        p1_ok_reg   <= tap_ok;
        p1_d2_reg   <= tap_d2;
        p2_ok_reg   <= p1_ok_reg;
        p2_d2_reg   <= p1_d2_reg;
        p2_v_reg    <= rd_q.value;
        p2_dsq_reg  <= 32'(diff) * 32'(diff);
        p3_ok_reg   <= p2_ok_reg;
        p3_v_reg    <= p2_v_reg;
        p3_xs_reg   <= (D2_W + 32)'(p2_d2_reg) * (D2_W + 32)'(inv_two_sigma_sq);
        p3_xg_reg   <= 64'(p2_dsq_reg) * 64'(inv_two_sigma_sq);
        p4_ok_reg   <= p3_ok_reg;
        p4_v_reg    <= p3_v_reg;
        p4_ws_reg   <= wlook(64'(p3_xs_reg), scale_zero);
        p4_wg_reg   <= wlook(p3_xg_reg, scale_zero);
        p5_v_reg    <= p4_v_reg;
        if (!p4_ok_reg) begin
            p5_wt_reg <= '0;
        end
        else if (box_mode) begin
            p5_wt_reg <= 16'd1;
        end
        else begin
            p5_wt_reg <= ww[31:16];
        end
        p6_wt_reg   <= p5_wt_reg;
        p6_prod_reg <= 32'(p5_wt_reg) * 32'(p5_v_reg);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
            p4_vld_reg <= 1'b0;
            p5_vld_reg <= 1'b0;
            p6_vld_reg <= 1'b0;
        end
        else begin
            p1_vld_reg <= tap_issue;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
            p4_vld_reg <= p3_vld_reg;
            p5_vld_reg <= p4_vld_reg;
            p6_vld_reg <= p5_vld_reg;
        end
    end

    always_comb begin
        trial = {rem_reg, quo_reg[SAMPLE_W-1]} - (WSUM_W + 2)'(wsum_reg);
        ge    = ({rem_reg, quo_reg[SAMPLE_W-1]} >= (WSUM_W + 2)'(wsum_reg));
    end

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        gc_next        = gc_reg;
        tk_next        = tk_reg;
        tm_next        = tm_reg;
        wsum_next      = wsum_reg;
        sum_next       = sum_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        bit_cnt_next   = bit_cnt_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_item_next  = res_item_reg;
        q_pop          = 1'b0;

        if (p6_vld_reg) begin
            wsum_next = wsum_reg + WSUM_W'(p6_wt_reg);
            sum_next  = sum_reg + SUM_W'(p6_prod_reg);
        end

        unique case (state_reg)
            S_IDLE: begin
                if (!q_empty) begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    if (q_cmd.do_write) begin
                        state_next = S_WRITE;
                    end
                    else if (q_cmd.do_emit) begin
                        state_next = S_CTR_RD;
                    end
                end
            end
            S_WRITE: begin
                state_next = cmd_reg.do_emit ? S_CTR_RD : S_IDLE;
            end
            S_CTR_RD: begin
                wsum_next  = '0;
                sum_next   = '0;
                state_next = S_CTR_WAIT;
            end
            S_CTR_WAIT: begin
                gc_next    = rd_q.guide;
                tk_next    = TAP_LO;
                tm_next    = TAP_LO;
                state_next = S_TAPS;
            end
            S_TAPS: begin
                if (tm_reg == TAP_HI) begin
                    tm_next = TAP_LO;
                    tk_next = tk_reg + 3'sd1;
                    if (tk_reg == TAP_HI) begin
                        state_next = S_DRAIN;
                    end
                end
                else begin
                    tm_next = tm_reg + 3'sd1;
                end
            end
            S_DRAIN: begin
                if (!(p1_vld_reg || p2_vld_reg || p3_vld_reg ||
                      p4_vld_reg || p5_vld_reg || p6_vld_reg)) begin
                    rem_next     = (WSUM_W + 1)'(sum_reg[SUM_W-1:SAMPLE_W]);
                    quo_next     = sum_reg[SAMPLE_W-1:0];
                    bit_cnt_next = '0;
                    state_next   = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                rem_next = ge ? trial[WSUM_W:0] : {rem_reg[WSUM_W-1:0], quo_reg[SAMPLE_W-1]};
                quo_next = {quo_reg[SAMPLE_W-2:0], ge};
                bit_cnt_next = bit_cnt_reg + DIV_CW'(1);
                if (bit_cnt_reg == DIV_CW'(SAMPLE_W - 1)) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!res_valid_reg || !res_stall) begin
                    res_valid_next               = 1'b1;
                    res_item_next.filtered_value = quo_reg;
                    res_item_next.frame_end      = cmd_reg.frame_end;
                    state_next                   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        cmd_reg      <= cmd_next;
        gc_reg       <= gc_next;
        tk_reg       <= tk_next;
        tm_reg       <= tm_next;
        wsum_reg     <= wsum_next;
        sum_reg      <= sum_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        bit_cnt_reg  <= bit_cnt_next;
        res_item_reg <= res_item_next;
    end

endmodule

FILE: verif/joint_bilateral_filter_5x5_test.sv
`timescale 1ns / 1ps
module joint_bilateral_filter_5x5_test;
    import jbf_pkg::*;

    localparam int RING_SIZE = 5 * 1024;
    localparam int HALO      = 2;
    localparam int LIMIT     = 4000000;

    // Filter predictor and the queue of filtered pixels it has promised.
    class filter_scoreboard;
        logic [15:0] weight_lut [256];
        logic [15:0] ring_v [RING_SIZE];
        logic [15:0] ring_g [RING_SIZE];
        int unsigned reg_w, reg_h, reg_scale, reg_box;
        int unsigned fw, fh, in_row, in_col, out_row, out_col;
        bit          draining;
        out_item_t   pending [$];
        int          errors;

        function new();
            for (int i = 0; i < 256; i++) begin
                weight_lut[i] = decay(i);
            end
            reg_w = 320;
            reg_h = 240;
            reg_scale = 32768;
            reg_box = 0;
            fw = 320;
            fh = 240;
            in_row = 0;
            in_col = 0;
            out_row = 0;
            out_col = 0;
            draining = 0;
            errors = 0;
        endfunction

        // exp(-16*i/256) in Q0.16: series on the fraction, 1/e per whole unit.
        function logic [15:0] decay(int i);
            logic [63:0] x, frac, term, v, r;
            longint      acc;
            int          whole;
            x = (64'(i) << 36) / 256;
            whole = int'(x >> 32);
            frac = x & 64'hFFFF_FFFF;
            term = 64'h1_0000_0000;
            acc = longint'(term);
            for (int k = 1; k <= 24; k++) begin
                term = ((term * frac) >> 32) / 64'(k);
                if (k % 2 == 1) acc = acc - longint'(term);
                else acc = acc + longint'(term);
            end
            v = (acc > 0) ? 64'(acc) : 64'd0;
            for (int j = 0; j < whole; j++) begin
                v = (v * 64'd1580030169 + 64'h8000_0000) >> 32;
            end
            r = (v + 64'd32768) >> 16;
            return (r > 64'd65535) ? 16'hFFFF : r[15:0];
        endfunction

        function logic [63:0] falloff(logic [63:0] d);
            logic [63:0] x;
            if (reg_scale == 0) return 64'(weight_lut[0]);
            if (d >= 64'h1_0000_0000) return 0;
            x = d * 64'(reg_scale);
            if (x >= 64'h10_0000) return 0;
            return 64'(weight_lut[(x * 256) >> 20]);
        endfunction

        function void write_reg(cfg_index_t idx, logic [31:0] val);
            case (idx)
                CFG_IMAGE_WIDTH:      reg_w = val[10:0];
                CFG_IMAGE_HEIGHT:     reg_h = val[12:0];
                CFG_INV_TWO_SIGMA_SQ: reg_scale = val;
                CFG_BOX_MODE:         reg_box = val[0];
            endcase
        endfunction

        function void produce_pixel();
            out_item_t   res;
            int unsigned o, gc, q;
            int          rr, cc;
            logic [63:0] sum, wsum, wt, diff;
            o = out_row * fw + out_col;
            gc = ring_g[o % RING_SIZE];
            sum = 0;
            wsum = 0;
            for (int k = -HALO; k <= HALO; k++) begin
                for (int m = -HALO; m <= HALO; m++) begin
                    rr = int'(out_row) + k;
                    cc = int'(out_col) + m;
                    if (rr >= 0 && rr < int'(fh) && cc >= 0 && cc < int'(fw)) begin
                        q = (rr * fw + cc) % RING_SIZE;
                        if (reg_box != 0) begin
                            wt = 1;
                        end
                        else begin
                            diff = (ring_g[q] > gc) ? 64'(ring_g[q] - gc)
                                                    : 64'(gc - ring_g[q]);
                            wt = (falloff(64'(k * k + m * m)) * falloff(diff * diff)) >> 16;
                        end
                        wsum += wt;
                        sum += wt * 64'(ring_v[q]);
                    end
                end
            end
            res.filtered_value = (wsum != 0) ? 16'(sum / wsum) : 16'd0;
            res.frame_end = (o + 1 == fw * fh);
            pending.push_back(res);
            if (res.frame_end) begin
                in_row = 0;
                in_col = 0;
                out_row = 0;
                out_col = 0;
                draining = 0;
            end
            else if (++out_col == fw) begin
                out_col = 0;
                out_row++;
            end
        endfunction

        // Called for every item the block accepts on its pixel channel.
        function void note_input(in_item_t it);
            int unsigned n;
            if (draining) begin
                produce_pixel();
                return;
            end
            if (it.opcode == OP_FLUSH) return;
            if (in_row == 0 && in_col == 0) begin
                fw = (reg_w == 0) ? 1 : ((reg_w > 1024) ? 1024 : reg_w);
                fh = (reg_h == 0) ? 1 : reg_h;
            end
            n = in_row * fw + in_col;
            ring_v[n % RING_SIZE] = it.pixel_value;
            ring_g[n % RING_SIZE] = it.guide_value;
            if (++in_col == fw) begin
                in_col = 0;
                in_row++;
            end
            if (n + 1 == fw * fh) draining = 1;
            if (n >= HALO * fw + HALO) produce_pixel();
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result value=%h frame_end=%b",
                         $time, got.filtered_value, got.frame_end);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.filtered_value !== want.filtered_value) begin
                $display("%0t: filtered_value expected %h actual %h",
                         $time, want.filtered_value, got.filtered_value);
                errors++;
            end
            if (got.frame_end !== want.frame_end) begin
                $display("%0t: frame_end expected %b actual %b",
                         $time, want.frame_end, got.frame_end);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        pix_valid;
    logic        pix_stall;
    in_item_t    pix_item;
    logic        res_valid;
    logic        res_stall;
    out_item_t   res_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    filter_scoreboard board;
    int unsigned      sent;
    int unsigned      hold_off;
    int unsigned      cycles;
    bit               pressed;

    joint_bilateral_filter_5x5 uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_item  (pix_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // The run ends here if the block hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("joint_bilateral_filter_5x5_test NOT OK");
            $finish;
        end
    end

    // Result side. Each accepted item draws a short stall, which may be zero, for
    // the next one, and a long hold-off requested by the stimulus is counted down here so
    // that the command queue fills and the pixel channel backs up.
    initial
    begin : result_side
        int unsigned pause;
        pause = 0;
        res_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (res_valid && !res_stall) begin
                board.check_result(res_item);
                pause = $urandom_range(0, 3);
                if ($urandom_range(0, 3) == 0) pause = 0;
            end
            if (hold_off > 0) begin
                hold_off--;
                res_stall <= 1'b1;
            end
            else if (pause > 0) begin
                pause--;
                res_stall <= 1'b1;
            end
            else begin
                res_stall <= 1'b0;
            end
        end
    end

    // Offer one item after a random gap and hold it until the block takes it.
    // Valid stays high into the next item when no gap is drawn.
    task automatic offer_item(opcode_t op);
        int unsigned gap;
        in_item_t    it;
        gap = $urandom_range(0, 3);
        it.opcode = op;
        it.pixel_value = 16'($urandom);
        it.guide_value = 16'($urandom);
        if ($urandom_range(0, 15) == 0) it.pixel_value = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0;
        if ($urandom_range(0, 15) == 0) it.guide_value = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0;
        if (gap > 0) begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_item <= it;
        do @(posedge clk); while (pix_stall);
        board.note_input(it);
        sent++;
    endtask

    // Registers may change only once the block has gone quiet, so wait for
    // every promised result and then for one full result computation.
    task automatic settle();
        pix_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic program_regs(logic [31:0] w, logic [31:0] h, logic [31:0] scale,
                                logic [31:0] box);
        logic [31:0] vals [4];
        vals = '{w, h, scale, box};
        settle();
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            board.write_reg(cfg_index_t'(i), vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // One whole frame: its pixels, then the flushes that drain the outputs
    // still owed. Noisy frames mix in flushes that owe nothing, drain with
    // pixels that only act as flushes, and may add a spare flush at the end.
    task automatic run_frame(bit noisy);
        int unsigned total, lag, owed;
        total = board.reg_w == 0 ? 1 : (board.reg_w > 1024 ? 1024 : board.reg_w);
        lag = 2 * total + 2;
        total = total * (board.reg_h == 0 ? 1 : board.reg_h);
        owed = (total < lag) ? total : lag;
        for (int i = 0; i < total; i++) begin
            if (noisy && $urandom_range(0, 7) == 0) offer_item(OP_FLUSH);
            offer_item(OP_PIXEL);
        end
        for (int i = 0; i < owed; i++) begin
            offer_item((noisy && $urandom_range(0, 2) == 0) ? OP_PIXEL : OP_FLUSH);
        end
        if (noisy && $urandom_range(0, 1) == 0) offer_item(OP_FLUSH);
    endtask

    function automatic logic [31:0] pick_scale();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(1, 16);
            3: return $urandom;
            default: return $urandom_range(1, 32'h20000);
        endcase
    endfunction

    initial
    begin
        board = new();
        sent = 0;
        hold_off = 0;
        cycles = 0;
        pressed = 1'b0;
        rst_n = 1'b0;
        pix_valid = 1'b0;
        pix_item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: a single-pixel frame, a flush with nothing owed,
        // zero sizes taken as one, box mode, and the scale at both extremes.
        program_regs(1, 1, 32'd32768, 0);
        offer_item(OP_FLUSH);
        run_frame(0);
        program_regs(0, 0, 32'd0, 1);
        run_frame(1);
        program_regs(3, 2, 32'hFFFF_FFFF, 0);
        run_frame(1);
        program_regs(4, 4, 32'd1, 0);
        run_frame(0);

        // A tall frame with a single column.
        program_regs(0, 300, 32'd300, 0);
        run_frame(0);

        // Random part on small frames. The first round has the result side
        // hold off for a long stretch while pixels keep coming.
        while (sent < 1200) begin
            program_regs($urandom_range(1, 12), $urandom_range(1, 10), pick_scale(),
                         $urandom_range(0, 3) == 0);
            if (!pressed ||
                (hold_off == 0 && cycles < 400000 && $urandom_range(0, 3) == 0)) begin
                hold_off = 600;
                pressed = 1'b1;
            end
            repeat ($urandom_range(1, 3)) run_frame($urandom_range(0, 2) != 0);
        end

        settle();
        if (board.errors == 0) begin
            $display("joint_bilateral_filter_5x5_test OK");
        end
        else begin
            $display("joint_bilateral_filter_5x5_test NOT OK");
        end
        $finish;
    end

endmodule
